/* hdl/fdbf_pkg.sv */
package fdbf_pkg;

  // array geometry
  localparam int BAND_COUNT = 256;
  localparam int BEAM_COUNT = 8;
  localparam int MIC_COUNT  = 4;

  // field and datapath widths
  localparam int BEAM_W = 3;
  localparam int BAND_W = 8;
  localparam int MIC_W  = 2;
  localparam int SMP_W  = 16;
  localparam int PROD_W = 2 * SMP_W;
  localparam int SUM_W  = PROD_W + 4;
  localparam int OUT_W  = 19;

  // per-cell weight memory: one entry per beam and band
  localparam int CELL_DEPTH = BEAM_COUNT * BAND_COUNT;
  localparam int ADDR_W     = (CELL_DEPTH > 1) ? $clog2(CELL_DEPTH) : 1;

  // request kinds
  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_PROC  = 1'b1;

  // request token handed from cell to cell
  typedef struct packed {
    logic                                valid;
    logic                                action;
    logic                                in_range;
    logic [BEAM_W-1:0]                   beam;
    logic [BAND_W-1:0]                   band;
    logic [MIC_W-1:0]                    mic;
    logic signed [SMP_W-1:0]             w_re;
    logic signed [SMP_W-1:0]             w_im;
    logic [MIC_COUNT-1:0][SMP_W-1:0]     s_re;
    logic [MIC_COUNT-1:0][SMP_W-1:0]     s_im;
    logic signed [SUM_W-1:0]             sum_re;
    logic signed [SUM_W-1:0]             sum_im;
  } tok_t;

endpackage

/* hdl/fdbf_cell.sv */
module fdbf_cell (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  fdbf_pkg::tok_t tin,
  output fdbf_pkg::tok_t tout
);
  import fdbf_pkg::*;

  logic [PROD_W-1:0]      mem [CELL_DEPTH];
  logic [ADDR_W-1:0]      addr;
  logic                   wr_en;
  logic [PROD_W-1:0]      rd;
  tok_t                   ta;
  tok_t                   tb;
  tok_t                   tout_next;
  logic signed [SMP_W-1:0] wr;
  logic signed [SMP_W-1:0] wi;
  logic signed [SMP_W-1:0] sr;
  logic signed [SMP_W-1:0] si;
  logic signed [PROD_W-1:0] p_rr;
  logic signed [PROD_W-1:0] p_ii;
  logic signed [PROD_W-1:0] p_ri;
  logic signed [PROD_W-1:0] p_ir;

  // weight address for this mic: beam-major, then band
  assign addr  = ADDR_W'(int'(tin.beam) * BAND_COUNT + int'(tin.band));
  // a write lands in the cell where its mic countdown reaches zero
  assign wr_en = en && tin.valid && (tin.action == ACT_WRITE) && tin.in_range
                 && (tin.mic == '0);

  // weight memory, one port written and one read per cycle while en is high
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= {tin.w_re, tin.w_im};
    end
    if (en) begin
      rd <= mem[addr];
    end
  end

  // stage a: token beside the weight read
  always_ff @(posedge clk) begin
    if (rst) begin
      ta.valid <= 1'b0;
    end else if (en) begin
      ta <= tin;
    end
  end

  // out-of-range beam or band contributes nothing
  assign wr = ta.in_range ? $signed(rd[PROD_W-1:SMP_W]) : '0;
  assign wi = ta.in_range ? $signed(rd[SMP_W-1:0]) : '0;
  assign sr = $signed(ta.s_re[0]);
  assign si = $signed(ta.s_im[0]);

  // stage b: four partial products of the complex multiply
  always_ff @(posedge clk) begin
    if (en) begin
      p_rr <= wr * sr;
      p_ii <= wi * si;
      p_ri <= wr * si;
      p_ir <= wi * sr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tb.valid <= 1'b0;
    end else if (en) begin
      tb <= ta;
    end
  end

  // accumulate and hand the remaining samples to the next cell
  always_comb begin
    tout_next        = tb;
    tout_next.sum_re = tb.sum_re + SUM_W'(p_rr) - SUM_W'(p_ii);
    tout_next.sum_im = tb.sum_im + SUM_W'(p_ri) + SUM_W'(p_ir);
    tout_next.s_re   = {SMP_W'(0), tb.s_re[MIC_COUNT-1:1]};
    tout_next.s_im   = {SMP_W'(0), tb.s_im[MIC_COUNT-1:1]};
    tout_next.mic    = tb.mic - MIC_W'(1);
  end

  // stage c: token register toward the next cell
  always_ff @(posedge clk) begin
    if (rst) begin
      tout.valid <= 1'b0;
    end else if (en) begin
      tout <= tout_next;
    end
  end

endmodule

/* hdl/fdbf_out.sv */
module fdbf_out (
  input  logic                                 clk,
  input  logic                                 rst,
  input  fdbf_pkg::tok_t                       tail,
  output logic                                 en,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [fdbf_pkg::BAND_W-1:0]          out_band,
  output logic signed [fdbf_pkg::OUT_W-1:0]    out_re,
  output logic signed [fdbf_pkg::OUT_W-1:0]    out_im,
  output logic                                 skid_valid
);
  import fdbf_pkg::*;

  localparam int SH_W = SUM_W - 15;
  localparam logic signed [SH_W-1:0] SH_MAX = SH_W'(2 ** (OUT_W - 1) - 1);
  localparam logic signed [SH_W-1:0] SH_MIN = SH_W'(-(2 ** (OUT_W - 1)));

  logic                     res_valid;
  logic                     take;
  logic                     load_out;
  logic signed [OUT_W-1:0]  res_re;
  logic signed [OUT_W-1:0]  res_im;
  logic [BAND_W-1:0]        skid_band;
  logic signed [OUT_W-1:0]  skid_re;
  logic signed [OUT_W-1:0]  skid_im;

  // arithmetic shift right by 15 then clamp to the output range
  function automatic logic signed [OUT_W-1:0] sat_shift(input logic signed [SUM_W-1:0] v);
    logic signed [SH_W-1:0] sh;
    sh = $signed(v[SUM_W-1:15]);
    if (sh > SH_MAX) begin
      sh = SH_MAX;
    end else if (sh < SH_MIN) begin
      sh = SH_MIN;
    end
    return sh[OUT_W-1:0];
  endfunction

  assign res_re    = sat_shift(tail.sum_re);
  assign res_im    = sat_shift(tail.sum_im);
  assign res_valid = tail.valid && (tail.action == ACT_PROC);

  // chain moves while the skid slot is free
  assign en       = !skid_valid;
  assign take     = en && res_valid;
  assign load_out = !out_valid || out_ready;

  // output register and skid slot control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (load_out) begin
      out_valid  <= skid_valid || take;
      skid_valid <= 1'b0;
    end else if (take) begin
      skid_valid <= 1'b1;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (load_out) begin
      if (skid_valid) begin
        out_band <= skid_band;
        out_re   <= skid_re;
        out_im   <= skid_im;
      end else begin
        out_band <= tail.band;
        out_re   <= res_re;
        out_im   <= res_im;
      end
    end else if (take) begin
      skid_band <= tail.band;
      skid_re   <= res_re;
      skid_im   <= res_im;
    end
  end

endmodule

/* hdl/freq_domain_beamformer_4mic.sv */
// Four-mic frequency-domain filter-and-sum beamformer.
// Input channel (in_valid/in_ready) carries one request per cycle while
// in_ready is high. With action = 0 the request writes weight {re0, im0}
// for (beam, mic, band); it gives no result. With action = 1 it carries the
// four complex samples of one band and gives one result: the sum of sample
// times weight over the four mics, arithmetically shifted right by 15 and
// clamped to 19 bits. A weight must be written before any request reads it.
// Requests run through a row of four identical cells, one per mic, each with
// its own weight memory (beam x band entries) and three register stages:
// weight read, complex multiply, accumulate. A write lands in its mic's cell
// as it passes, so requests keep their order.
// Throughput: one request per cycle while in_ready is high.
// When out_ready is low the result waits in the output register; one more
// result fits in a skid slot, after which in_ready drops and the row holds.
// Reset (rst, synchronous) empties the row and the output; the weight
// memories are not cleared.
module freq_domain_beamformer_4mic (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                action,
  input  logic [fdbf_pkg::BEAM_W-1:0]         beam,
  input  logic [fdbf_pkg::BAND_W-1:0]         band,
  input  logic [fdbf_pkg::MIC_W-1:0]          mic,
  input  logic signed [fdbf_pkg::SMP_W-1:0]   re0,
  input  logic signed [fdbf_pkg::SMP_W-1:0]   im0,
  input  logic signed [fdbf_pkg::SMP_W-1:0]   re1,
  input  logic signed [fdbf_pkg::SMP_W-1:0]   im1,
  input  logic signed [fdbf_pkg::SMP_W-1:0]   re2,
  input  logic signed [fdbf_pkg::SMP_W-1:0]   im2,
  input  logic signed [fdbf_pkg::SMP_W-1:0]   re3,
  input  logic signed [fdbf_pkg::SMP_W-1:0]   im3,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [fdbf_pkg::BAND_W-1:0]         out_band,
  output logic signed [fdbf_pkg::OUT_W-1:0]   out_re,
  output logic signed [fdbf_pkg::OUT_W-1:0]   out_im
);
  import fdbf_pkg::*;

  tok_t head;
  tok_t link [MIC_COUNT+1];
  logic en;
  logic skid_valid;

  assign in_ready = en;

  // build the request token entering the row
  always_comb begin
    head          = '0;
    head.valid    = in_valid && in_ready;
    head.action   = action;
    head.in_range = (int'(beam) < BEAM_COUNT) && (int'(band) < BAND_COUNT);
    head.beam     = beam;
    head.band     = band;
    head.mic      = mic;
    head.w_re     = re0;
    head.w_im     = im0;
    head.s_re     = {re3, re2, re1, re0};
    head.s_im     = {im3, im2, im1, im0};
    head.sum_re   = '0;
    head.sum_im   = '0;
  end

  assign link[0] = head;

  // one cell per mic
  for (genvar g = 0; g < MIC_COUNT; g++) begin : g_cell
    fdbf_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .en   (en),
      .tin  (link[g]),
      .tout (link[g+1])
    );
  end

  // scaling, clamping and output buffering
  fdbf_out u_out (
    .clk        (clk),
    .rst        (rst),
    .tail       (link[MIC_COUNT]),
    .en         (en),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_band   (out_band),
    .out_re     (out_re),
    .out_im     (out_im),
    .skid_valid (skid_valid)
  );

`ifndef SYNTHESIS
  // a filled skid slot always sits behind a held result
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid slot full without a result in the output register");

  // a held result plus a new one fills the skid slot
  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready && !skid_valid && link[MIC_COUNT].valid
     && (link[MIC_COUNT].action == ACT_PROC)) |=> skid_valid)
    else $error("result lost while output stalled");

  // a draining skid slot refills the output register
  a_skid_drain: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && skid_valid) |=> (out_valid && !skid_valid))
    else $error("skid slot result not moved to output");
`endif

endmodule
